// File: hdl/ihv_pkg.sv
// Package for the IPv4 header validator: verdict codes, header offsets and
// the packet summary handed from the parser to the checker. No dependencies.
`timescale 1ns / 1ps

package ihv_pkg;

    // Verdict codes
    typedef enum logic [2:0] {
        VERDICT_UDP         = 3'd0,
        VERDICT_ICMP        = 3'd1,
        VERDICT_BAD_LEN     = 3'd2,
        VERDICT_UNSUPPORTED = 3'd3,
        VERDICT_BAD_CSUM    = 3'd4,
        VERDICT_WRONG_DST   = 3'd5
    } verdict_t;

    // Header byte offsets
    localparam logic [15:0] OFF_VER_IHL   = 16'd0;
    localparam logic [15:0] OFF_TLEN_HI   = 16'd2;
    localparam logic [15:0] OFF_TLEN_LO   = 16'd3;
    localparam logic [15:0] OFF_FRAG_HI   = 16'd6;
    localparam logic [15:0] OFF_FRAG_LO   = 16'd7;
    localparam logic [15:0] OFF_PROTO     = 16'd9;
    localparam logic [15:0] OFF_SRC_FIRST = 16'd12;
    localparam logic [15:0] OFF_SRC_LAST  = 16'd15;
    localparam logic [15:0] OFF_DST_FIRST = 16'd16;
    localparam logic [15:0] OFF_DST_LAST  = 16'd19;

    // Protocol and length constants
    localparam logic [15:0] HDR_MIN_LEN = 16'd20;
    localparam logic [3:0]  IP_VERSION  = 4'd4;
    localparam logic [3:0]  IHL_MIN     = 4'd5;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam logic [7:0]  PROTO_ICMP  = 8'd1;
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
    localparam logic [15:0] SUM_GOOD    = 16'hFFFF;

    // Everything the checker needs about one finished packet
    typedef struct packed {
        logic [15:0] pkt_len;
        logic [7:0]  ver_hl;
        logic [15:0] ip_len;
        logic [15:0] frag;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sum;
    } hdr_summary_t;

endpackage

// File: hdl/ihv_ifs.sv
// Channel interfaces of the IPv4 header validator: byte input, verdict
// output and configuration write. Depends on nothing.
`timescale 1ns / 1ps

interface ihv_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ihv_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic [31:0] source_ip;
    logic [5:0]  header_bytes;
    logic [15:0] payload_bytes;

    modport source (output valid, output verdict, output source_ip,
                    output header_bytes, output payload_bytes, input ready);
    modport sink   (input valid, input verdict, input source_ip,
                    input header_bytes, input payload_bytes, output ready);
endinterface

interface ihv_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/ihv_parser.sv
// Byte parser: captures header fields, keeps the ones' complement sum and
// the byte count, and registers a summary on the last byte.
// Depends on ihv_pkg and ihv_ifs.
`timescale 1ns / 1ps

module ihv_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    ihv_rx_if.sink                rx,
    output ihv_pkg::hdr_summary_t summary,
    output logic                  summary_valid,
    input  logic                  summary_ready
);

    logic [15:0] count_reg, count_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  hold_reg, hold_next;
    logic [7:0]  vihl_reg, vihl_next;
    logic [15:0] tlen_reg, tlen_next;
    logic [15:0] frag_reg, frag_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;

    ihv_pkg::hdr_summary_t summary_reg, summary_next;
    logic                  svalid_reg, svalid_next;

    logic        accept;
    logic [15:0] idx;
    logic [5:0]  hlen;
    logic        in_hdr;
    logic [16:0] raw_sum;
    logic [15:0] folded;

    // Take a word whenever the summary slot is free or draining
    assign rx.ready = !svalid_reg || summary_ready;
    assign accept   = rx.valid && rx.ready;
    assign idx      = count_reg;

    // Field capture at fixed offsets
    always_comb
    begin
        vihl_next  = vihl_reg;
        tlen_next  = tlen_reg;
        frag_next  = frag_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        if (idx == ihv_pkg::OFF_VER_IHL)
        begin
            vihl_next = rx.data_byte;
        end
        else if (idx == ihv_pkg::OFF_TLEN_HI || idx == ihv_pkg::OFF_TLEN_LO)
        begin
            tlen_next = {tlen_reg[7:0], rx.data_byte};
        end
        else if (idx == ihv_pkg::OFF_FRAG_HI || idx == ihv_pkg::OFF_FRAG_LO)
        begin
            frag_next = {frag_reg[7:0], rx.data_byte};
        end
        else if (idx == ihv_pkg::OFF_PROTO)
        begin
            proto_next = rx.data_byte;
        end
        else if (idx >= ihv_pkg::OFF_SRC_FIRST && idx <= ihv_pkg::OFF_SRC_LAST)
        begin
            src_next = {src_reg[23:0], rx.data_byte};
        end
        else if (idx >= ihv_pkg::OFF_DST_FIRST && idx <= ihv_pkg::OFF_DST_LAST)
        begin
            dst_next = {dst_reg[23:0], rx.data_byte};
        end
    end

    // Header sum over complete big-endian words with end-around carry
    assign hlen    = {vihl_next[3:0], 2'b00};
    assign in_hdr  = idx < {10'd0, hlen};
    assign raw_sum = {1'b0, sum_reg} + {1'b0, hold_reg, rx.data_byte};
    assign folded  = raw_sum[15:0] + {15'd0, raw_sum[16]};

    always_comb
    begin
        hold_next = hold_reg;
        sum_next  = sum_reg;
        if (in_hdr && !idx[0])
        begin
            hold_next = rx.data_byte;
        end
        else if (in_hdr && idx[0])
        begin
            sum_next = folded;
        end
    end

    // Saturating count, which is also the packet length so far
    assign count_next = (idx == ihv_pkg::COUNT_MAX) ? idx : idx + 16'd1;

    // Summary slot
    always_comb
    begin
        summary_next.pkt_len = count_next;
        summary_next.ver_hl  = vihl_next;
        summary_next.ip_len  = tlen_next;
        summary_next.frag    = frag_next;
        summary_next.proto   = proto_next;
        summary_next.src     = src_next;
        summary_next.dst     = dst_next;
        summary_next.sum     = sum_next;
        if (accept && rx.last_byte)
        begin
            svalid_next = 1'b1;
        end
        else if (summary_ready)
        begin
            svalid_next = 1'b0;
        end
        else
        begin
            svalid_next = svalid_reg;
        end
    end

    // Per-packet state: advance on each word, clear after the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_reg    <= '0;
            hold_reg   <= '0;
            vihl_reg   <= '0;
            tlen_reg   <= '0;
            frag_reg   <= '0;
            proto_reg  <= '0;
            src_reg    <= '0;
            dst_reg    <= '0;
            svalid_reg <= 1'b0;
        end
        else
        begin
            svalid_reg <= svalid_next;
            if (accept && rx.last_byte)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                hold_reg  <= '0;
                vihl_reg  <= '0;
                tlen_reg  <= '0;
                frag_reg  <= '0;
                proto_reg <= '0;
                src_reg   <= '0;
                dst_reg   <= '0;
            end
            else if (accept)
            begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
                hold_reg  <= hold_next;
                vihl_reg  <= vihl_next;
                tlen_reg  <= tlen_next;
                frag_reg  <= frag_next;
                proto_reg <= proto_next;
                src_reg   <= src_next;
                dst_reg   <= dst_next;
            end
        end
    end

    // Summary payload: load on the last byte only
    always_ff @(posedge clk)
    begin
        if (accept && rx.last_byte)
        begin
            summary_reg <= summary_next;
        end
    end

    assign summary       = summary_reg;
    assign summary_valid = svalid_reg;

endmodule

// File: hdl/ihv_checker.sv
// Verdict checker: holds local_ip, runs the ordered header checks on a
// packet summary and registers the result word. Depends on ihv_pkg, ihv_ifs.
`timescale 1ns / 1ps

module ihv_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    ihv_cfg_if.sink               cfg,
    input  ihv_pkg::hdr_summary_t summary,
    input  logic                  summary_valid,
    output logic                  summary_ready,
    ihv_res_if.source             res
);

    logic [31:0]       local_ip_reg;
    logic              ovalid_reg;
    ihv_pkg::verdict_t verdict_reg, verdict_next;
    logic [31:0]       src_reg;
    logic [5:0]        hlen_reg;
    logic [15:0]       payload_reg, payload_next;

    logic [3:0]  ihl;
    logic [5:0]  hlen;
    logic [15:0] hlen_w;
    logic        take;

    // Configuration is always accepted
    assign cfg.ready = 1'b1;

    // Result slot is free when empty or being drained
    assign take          = !ovalid_reg || res.ready;
    assign summary_ready = take;

    assign ihl    = summary.ver_hl[3:0];
    assign hlen   = {ihl, 2'b00};
    assign hlen_w = {10'd0, hlen};

    // Ordered checks, first failure wins
    always_comb
    begin
        payload_next = '0;
        if (summary.pkt_len < ihv_pkg::HDR_MIN_LEN)
        begin
            verdict_next = ihv_pkg::VERDICT_BAD_LEN;
        end
        else if (summary.ver_hl[7:4] != ihv_pkg::IP_VERSION)
        begin
            verdict_next = ihv_pkg::VERDICT_UNSUPPORTED;
        end
        else if (ihl < ihv_pkg::IHL_MIN || hlen_w > summary.pkt_len)
        begin
            verdict_next = ihv_pkg::VERDICT_BAD_LEN;
        end
        else if (summary.ip_len < hlen_w || summary.ip_len > summary.pkt_len)
        begin
            verdict_next = ihv_pkg::VERDICT_BAD_LEN;
        end
        else if (summary.sum != ihv_pkg::SUM_GOOD)
        begin
            verdict_next = ihv_pkg::VERDICT_BAD_CSUM;
        end
        else if (summary.frag[13:0] != 14'd0)
        begin
            verdict_next = ihv_pkg::VERDICT_UNSUPPORTED;
        end
        else if (summary.dst != local_ip_reg)
        begin
            verdict_next = ihv_pkg::VERDICT_WRONG_DST;
        end
        else if (summary.proto == ihv_pkg::PROTO_UDP)
        begin
            verdict_next = ihv_pkg::VERDICT_UDP;
            payload_next = summary.ip_len - hlen_w;
        end
        else if (summary.proto == ihv_pkg::PROTO_ICMP)
        begin
            verdict_next = ihv_pkg::VERDICT_ICMP;
            payload_next = summary.ip_len - hlen_w;
        end
        else
        begin
            verdict_next = ihv_pkg::VERDICT_UNSUPPORTED;
        end
    end

    // Control: local address and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg <= '0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                local_ip_reg <= cfg.data;
            end
            if (take)
            begin
                ovalid_reg <= summary_valid;
            end
        end
    end

    // Result payload: load when a summary moves in
    always_ff @(posedge clk)
    begin
        if (take && summary_valid)
        begin
            verdict_reg <= verdict_next;
            src_reg     <= summary.src;
            hlen_reg    <= hlen;
            payload_reg <= payload_next;
        end
    end

    assign res.valid         = ovalid_reg;
    assign res.verdict       = verdict_reg;
    assign res.source_ip     = src_reg;
    assign res.header_bytes  = hlen_reg;
    assign res.payload_bytes = payload_reg;

endmodule

// File: hdl/ipv4_header_validator_top.sv
// IPv4 header validator top level: wires the byte parser to the checker.
// Depends on ihv_pkg, ihv_ifs, ihv_parser and ihv_checker.
//
// Usage:
//   rx  - packet bytes from the first header byte on, last_byte set on the
//         final byte. One word is taken per cycle while rx.ready is high.
//   res - one verdict word per packet: verdict, source_ip, header_bytes and
//         payload_bytes (payload_bytes is zero unless the verdict is udp or
//         icmp).
//   cfg - writes local_ip; always ready, write only while the block is idle.
// Throughput: one byte per cycle while rx.ready is high, set by the field
//   capture and 16-bit ones' complement add in the parser.
// Path: the last byte loads the summary register, then the summary moves
//   into the result register, which drives res.valid; a full result slot
//   can hold the summary in between.
// Reset: rst_n clears the byte count, the running sum, the captured fields,
//   local_ip and both valid flags; the next byte starts a new packet.
// Stall: while res.ready is low the result word holds, one more summary
//   waits behind it, and rx.ready drops only once both are full.
`timescale 1ns / 1ps

module ipv4_header_validator_top (
    input  logic       clk,
    input  logic       rst_n,
    ihv_rx_if.sink     rx,
    ihv_cfg_if.sink    cfg,
    ihv_res_if.source  res
);

    ihv_pkg::hdr_summary_t summary;
    logic                  summary_valid;
    logic                  summary_ready;

    // Byte parser
    ihv_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx            (rx),
        .summary       (summary),
        .summary_valid (summary_valid),
        .summary_ready (summary_ready)
    );

    // Verdict checker
    ihv_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .summary       (summary),
        .summary_valid (summary_valid),
        .summary_ready (summary_ready),
        .res           (res)
    );

endmodule
